@@ design/jsu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and helper functions for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int unsigned MAX_BYTES = 4;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                n;
    logic                      data;
    logic                      done;
  } jsu_emit_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                n;
  } jsu_utf8_t;

  // Bit 4 set means the character is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b0, c[3:0] + 4'd9};
    end else begin
      r = 5'h10;
    end
    return r;
  endfunction

  function automatic jsu_utf8_t utf8_encode(input logic [20:0] cp);
    jsu_utf8_t r;
    r.bytes = '0;
    if (cp < 21'h80) begin
      r.bytes[0] = cp[7:0];
      r.n        = 3'd1;
    end else if (cp < 21'h800) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.n        = 3'd2;
    end else if (cp < 21'h10000) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.n        = 3'd3;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.n        = 3'd4;
    end
    return r;
  endfunction

endpackage

@@ design/jsu_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_decode
// Escape state machine: turns one input byte into up to four output bytes.
// ----------------------------------------------------------------------------
module jsu_decode import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  logic [7:0] in_byte,
  input  logic      in_string_end,
  output jsu_emit_t emit
);

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  typedef enum logic [5:0] {
    MODE_PLAIN   = 6'b000001,
    MODE_ESC     = 6'b000010,
    MODE_HEX1    = 6'b000100,
    MODE_WANT_BS = 6'b001000,
    MODE_WANT_U  = 6'b010000,
    MODE_HEX2    = 6'b100000
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        inv_r, inv_nxt;
  logic [9:0]  hh_r, hh_nxt;

  logic [4:0]  hv;
  logic [15:0] acc_upd;
  logic        inv_upd;
  logic [15:0] grp;
  logic        grp_low, grp_high;
  logic [7:0]  esc_byte;
  logic [20:0] cp;
  jsu_utf8_t   enc;
  jsu_emit_t   em;

  assign hv       = hex_value(in_byte);
  assign acc_upd  = hv[4] ? acc_r : {acc_r[11:0], hv[3:0]};
  assign inv_upd  = inv_r | hv[4];
  assign grp      = inv_upd ? 16'h0000 : acc_upd;
  assign grp_low  = (grp >= 16'hDC00) && (grp <= 16'hDFFF);
  assign grp_high = (grp >= 16'hD800) && (grp <= 16'hDBFF);
  assign cp       = (mode_r == MODE_HEX2) ? (21'h10000 + {1'b0, hh_r, grp[9:0]})
                                          : {5'd0, grp};
  assign enc      = utf8_encode(cp);

  always_comb begin
    unique case (in_byte)
      CH_B:    esc_byte = 8'h08;
      CH_F:    esc_byte = 8'h0C;
      CH_N:    esc_byte = 8'h0A;
      CH_R:    esc_byte = 8'h0D;
      CH_T:    esc_byte = 8'h09;
      default: esc_byte = in_byte;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    inv_nxt  = inv_r;
    hh_nxt   = hh_r;
    em       = '0;
    em.data  = 1'b1;
    unique case (mode_r)
      MODE_PLAIN: begin
        if (in_byte == CH_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else begin
          em.bytes[0] = in_byte;
          em.n        = 3'd1;
        end
      end
      MODE_ESC: begin
        if (in_byte == CH_U) begin
          mode_nxt = MODE_HEX1;
          acc_nxt  = '0;
          cnt_nxt  = '0;
          inv_nxt  = 1'b0;
        end else begin
          mode_nxt    = MODE_PLAIN;
          em.bytes[0] = esc_byte;
          em.n        = 3'd1;
        end
      end
      MODE_HEX1: begin
        acc_nxt = acc_upd;
        inv_nxt = inv_upd;
        if (cnt_r == 2'd3) begin
          cnt_nxt  = '0;
          mode_nxt = MODE_PLAIN;
          if (grp == 16'h0000 || grp_low) begin
            em.n = 3'd0;
          end else if (grp_high) begin
            hh_nxt   = grp[9:0];
            mode_nxt = MODE_WANT_BS;
          end else begin
            em.bytes = enc.bytes;
            em.n     = enc.n;
          end
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      MODE_WANT_BS: begin
        if (in_byte == CH_BSLASH) begin
          mode_nxt = MODE_WANT_U;
        end else begin
          mode_nxt    = MODE_PLAIN;
          em.bytes[0] = in_byte;
          em.n        = 3'd1;
        end
      end
      MODE_WANT_U: begin
        if (in_byte == CH_U) begin
          mode_nxt = MODE_HEX2;
          acc_nxt  = '0;
          cnt_nxt  = '0;
          inv_nxt  = 1'b0;
        end else begin
          mode_nxt    = MODE_PLAIN;
          em.bytes[0] = esc_byte;
          em.n        = 3'd1;
        end
      end
      MODE_HEX2: begin
        acc_nxt = acc_upd;
        inv_nxt = inv_upd;
        if (cnt_r == 2'd3) begin
          cnt_nxt  = '0;
          mode_nxt = MODE_PLAIN;
          if (grp_low) begin
            em.bytes = enc.bytes;
            em.n     = enc.n;
          end
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      default: begin
        mode_nxt = MODE_PLAIN;
      end
    endcase

    if (in_string_end) begin
      mode_nxt = MODE_PLAIN;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      inv_nxt  = 1'b0;
      hh_nxt   = '0;
      em.done  = 1'b1;
      if (em.n == 3'd0) begin
        em.bytes = '0;
        em.n     = 3'd1;
        em.data  = 1'b0;
      end
    end
  end

  assign emit = em;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      acc_r  <= '0;
      cnt_r  <= '0;
      inv_r  <= 1'b0;
      hh_r   <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      inv_r  <= inv_nxt;
      hh_r   <= hh_nxt;
    end
  end

endmodule

@@ design/jsu_outbuf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_outbuf
// Result register that holds the bytes of one request and shifts them out.
// ----------------------------------------------------------------------------
module jsu_outbuf import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  jsu_emit_t emit,
  output logic      out_valid,
  input  logic      out_stall,
  output logic [7:0] out_byte,
  output logic      out_byte_valid,
  output logic      out_run_last,
  output logic      out_string_done
);

  logic [MAX_BYTES-1:0][7:0] bytes_r, bytes_nxt;
  logic [2:0]                rem_r, rem_nxt;
  logic                      data_r, data_nxt;
  logic                      done_r, done_nxt;
  logic                      busy_r, busy_nxt;
  logic                      take, last, accept, load;

  assign take     = busy_r && !out_stall;
  assign last     = (rem_r == 3'd1);
  assign in_stall = busy_r && !(take && last);
  assign accept   = in_valid && !in_stall;
  assign load     = accept && (emit.n != 3'd0);

  always_comb begin
    bytes_nxt = bytes_r;
    rem_nxt   = rem_r;
    data_nxt  = data_r;
    done_nxt  = done_r;
    busy_nxt  = busy_r;
    if (take) begin
      bytes_nxt = {8'h00, bytes_r[MAX_BYTES-1:1]};
      rem_nxt   = rem_r - 3'd1;
      busy_nxt  = !last;
    end
    if (load) begin
      bytes_nxt = emit.bytes;
      rem_nxt   = emit.n;
      data_nxt  = emit.data;
      done_nxt  = emit.done;
      busy_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rem_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      rem_r  <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    data_r  <= data_nxt;
    done_r  <= done_nxt;
  end

  assign out_valid       = busy_r;
  assign out_byte        = bytes_r[0];
  assign out_byte_valid  = data_r;
  assign out_run_last    = last;
  assign out_string_done = done_r && last;

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r != 3'd0 && rem_r <= 3'd4))
    else $error("result count out of range while busy");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!busy_r || (take && last)))
    else $error("result register overwritten before drained");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_string_done) |-> out_run_last)
    else $error("string end flagged on a result that is not the last");

  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_byte_valid) |-> (out_string_done && out_byte == 8'h00))
    else $error("bare marker outside string end");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !last) |=> busy_r)
    else $error("result register emptied with bytes left");

endmodule

@@ design/json_string_unescape_utf8.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// JSON string body unescaper with UTF-16 escape to UTF-8 transcoding.
//
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_stall    in_byte, in_string_end
// out_      output     out_valid/out_stall  out_byte, out_byte_valid,
//                                           out_run_last, out_string_done
//
// An input request is decoded combinationally into one result register.
// A request that yields N bytes occupies the result register until its N bytes
// are taken, so plain text flows at one byte per cycle while out_stall is low.
// Requests that yield nothing are absorbed without occupying the register.
// Reset is synchronous and returns the decoder to plain text mode.
// A stalled output holds its byte, and the input stalls until the last byte
// of the held request is taken.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_string_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_run_last,
  output logic       out_string_done
);

  jsu_emit_t emit;
  logic      accept;

  assign accept = in_valid && !in_stall;

  jsu_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_byte       (in_byte),
    .in_string_end (in_string_end),
    .emit          (emit)
  );

  jsu_outbuf u_outbuf (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .emit            (emit),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_run_last    (out_run_last),
    .out_string_done (out_string_done)
  );

endmodule
